>>> src/csq_pkg.sv
// shared types and constants for the counting semaphore with wait queue
// no dependencies; imported by the cell and top-level modules
package csq_pkg;

	localparam logic signed [31:0] LEVEL_MAX = 32'sh7FFF_FFFF;

	typedef enum logic [2:0] {
		KIND_INIT     = 3'd0,
		KIND_WAIT     = 3'd1,
		KIND_TRY_WAIT = 3'd2,
		KIND_POST     = 3'd3,
		KIND_DESTROY  = 3'd4,
		KIND_CANCEL   = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_WOULD_BLOCK = 3'd1,
		ST_QUEUED      = 3'd2,
		ST_NOT_INIT    = 3'd3,
		ST_QUEUE_FULL  = 3'd4,
		ST_NOT_FOUND   = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		REG_INITIAL_LEVEL = 2'd0,
		REG_BINARY_MODE   = 2'd1,
		REG_QUEUE_BY_PRIO = 2'd2
	} reg_index_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_REMOVE_MATCH,
		CELL_REMOVE_HEAD
	} cell_op_t;

	// broadcast from the controller to every queue cell
	typedef struct packed {
		cell_op_t   op;
		logic       by_prio;
		logic [7:0] id;
		logic [7:0] prio;
	} cell_ctl_t;

endpackage

>>> src/csq_if.sv
// valid/ready channel interfaces: request, result and configuration write
// no dependencies; used on the top-level ports
interface csq_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] kind;
	logic [7:0] thread_id;
	logic [7:0] priority_req;

	modport source (output valid, kind, thread_id, priority_req, input ready);
	modport sink   (input valid, kind, thread_id, priority_req, output ready);
endinterface

interface csq_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [31:0] level_seen;
	logic        woken_valid;
	logic [7:0]  woken_thread;
	logic        woken_reason;
	logic        last;

	modport source (output valid, status, level_seen, woken_valid, woken_thread,
		woken_reason, last, input ready);
	modport sink   (input valid, status, level_seen, woken_valid, woken_thread,
		woken_reason, last, output ready);
endinterface

interface csq_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

>>> src/csq_cell.sv
// one entry of the waiter queue: thread id and priority
// depends on csq_pkg; a row of these forms the ordered queue
module csq_cell (
	input  logic              clk,
	input  csq_pkg::cell_ctl_t ctl,
	input  logic              occ,
	input  logic [7:0]        prev_id,
	input  logic [7:0]        prev_prio,
	input  logic [7:0]        next_id,
	input  logic [7:0]        next_prio,
	input  logic              sel_in,
	output logic              sel_out,
	output logic [7:0]        id,
	output logic [7:0]        prio
);
	import csq_pkg::*;

	logic [7:0] id_q;
	logic [7:0] prio_q;
	logic       cmp;
	logic       hit;

	assign id   = id_q;
	assign prio = prio_q;

	// insertion point: free slot, or, in priority mode, lower priority than the newcomer
	assign cmp = !occ || (ctl.by_prio && (prio_q < ctl.prio));

	// local selection term for the current operation
	always_comb begin
		case (ctl.op)
			CELL_INSERT:       hit = cmp;
			CELL_REMOVE_MATCH: hit = occ && (id_q == ctl.id);
			CELL_REMOVE_HEAD:  hit = 1'b1;
			default:           hit = 1'b0;
		endcase
	end

	// first-hit chain toward the tail
	assign sel_out = sel_in | hit;

	// shift right on insert, shift left on removal
	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_INSERT: begin
				if (sel_in) begin
					id_q   <= prev_id;
					prio_q <= prev_prio;
				end else if (hit) begin
					id_q   <= ctl.id;
					prio_q <= ctl.prio;
				end
			end
			CELL_REMOVE_MATCH, CELL_REMOVE_HEAD: begin
				if (sel_in || hit) begin
					id_q   <= next_id;
					prio_q <= next_prio;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

>>> src/counting_semaphore_wait_queue.sv
// counting semaphore with an ordered wait queue held in a row of cells
// path: an accepted item goes to the held item register, its result to
// the result register; one item per cycle while results drain; destroy
// gives one result per waiter; each insert or removal is one row update
// reset: asynchronous; level, live flag, waiter count and registers clear,
// queue entries are not cleared
module counting_semaphore_wait_queue #(
	parameter int QUEUE_DEPTH = 16
) (
	input logic      clk,
	input logic      arst_n,
	csq_cfg_if.sink  cfg,
	csq_req_if.sink  req,
	csq_rsp_if.source rsp
);
	import csq_pkg::*;

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	// configuration registers
	logic signed [31:0] initial_level_q;
	logic               binary_mode_q;
	logic               by_prio_q;

	// semaphore state
	logic signed [31:0] level_q;
	logic               live_q;
	logic [CNT_W-1:0]   count_q;
	logic               drain_q;

	// held item
	logic        busy_q;
	kind_t       kind_q;
	logic [7:0]  tid_q;
	logic [7:0]  prio_q;

	// result register
	logic        ov_q;
	status_t     status_q;
	logic [31:0] seen_q;
	logic        wv_q;
	logic [7:0]  wt_q;
	logic        wr_q;
	logic        last_q;

	// execute-step outputs
	logic               ex;
	logic               done;
	logic               emit;
	status_t            st_n;
	logic [31:0]        seen_n;
	logic               wv_n;
	logic               wr_n;
	logic               last_n;
	logic signed [31:0] level_n;
	logic               live_n;
	logic [CNT_W-1:0]   count_n;
	logic               drain_n;
	cell_ctl_t          ctl;

	// cell row wiring
	logic [7:0]       cell_id   [QUEUE_DEPTH];
	logic [7:0]       cell_prio [QUEUE_DEPTH];
	logic [QUEUE_DEPTH:0] sel;
	logic             level_pos;

	assign cfg.ready = 1'b1;

	// configuration write transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_level_q <= '0;
			binary_mode_q   <= 1'b0;
			by_prio_q       <= 1'b0;
		end else if (cfg.valid) begin
			case (reg_index_t'(cfg.index))
				REG_INITIAL_LEVEL: initial_level_q <= cfg.data;
				REG_BINARY_MODE:   binary_mode_q   <= cfg.data[0];
				REG_QUEUE_BY_PRIO: by_prio_q       <= cfg.data[0];
				default: begin
				end
			endcase
		end
	end

	// execute when an item is held and the result register can take a result
	assign ex        = busy_q && (!ov_q || rsp.ready);
	assign req.ready = !busy_q || (ex && done);
	assign level_pos = !level_q[31] && (level_q != 32'sd0);

	// queue operation broadcast to the cell row
	always_comb begin
		ctl.op      = CELL_HOLD;
		ctl.by_prio = by_prio_q;
		ctl.id      = tid_q;
		ctl.prio    = prio_q;
		if (ex) begin
			case (kind_q)
				KIND_CANCEL: begin
					ctl.op = CELL_REMOVE_MATCH;
				end
				KIND_WAIT: begin
					if (live_q && !level_pos && (count_q < CNT_W'(QUEUE_DEPTH)))
						ctl.op = CELL_INSERT;
				end
				KIND_POST: begin
					if (live_q && (count_q != '0))
						ctl.op = CELL_REMOVE_HEAD;
				end
				KIND_DESTROY: begin
					if ((live_q || drain_q) && (count_q != '0))
						ctl.op = CELL_REMOVE_HEAD;
				end
				default: begin
				end
			endcase
		end
	end

	// operation decode and next state
	always_comb begin
		done    = 1'b1;
		emit    = 1'b1;
		st_n    = ST_OK;
		seen_n  = '0;
		wv_n    = 1'b0;
		wr_n    = 1'b0;
		last_n  = 1'b1;
		level_n = level_q;
		live_n  = live_q;
		count_n = count_q;
		drain_n = 1'b0;
		case (kind_q)
			KIND_INIT: begin
				if (binary_mode_q)
					level_n = (initial_level_q != 32'sd0) ? 32'sd1 : 32'sd0;
				else
					level_n = initial_level_q;
				count_n = '0;
				live_n  = 1'b1;
			end
			KIND_CANCEL: begin
				if (sel[QUEUE_DEPTH])
					count_n = count_q - CNT_W'(1);
				else
					st_n = ST_NOT_FOUND;
			end
			KIND_WAIT: begin
				if (!live_q) begin
					st_n = ST_NOT_INIT;
				end else if (level_pos) begin
					level_n = level_q - 32'sd1;
				end else if (count_q >= CNT_W'(QUEUE_DEPTH)) begin
					st_n = ST_QUEUE_FULL;
				end else begin
					count_n = count_q + CNT_W'(1);
					st_n    = ST_QUEUED;
				end
			end
			KIND_TRY_WAIT: begin
				if (!live_q) begin
					st_n = ST_NOT_INIT;
				end else begin
					seen_n = level_q;
					if (level_pos)
						level_n = level_q - 32'sd1;
					else
						st_n = ST_WOULD_BLOCK;
				end
			end
			KIND_POST: begin
				if (!live_q) begin
					st_n = ST_NOT_INIT;
				end else if (count_q != '0) begin
					count_n = count_q - CNT_W'(1);
					wv_n    = 1'b1;
				end else if ((!binary_mode_q || !level_pos) && (level_q != LEVEL_MAX)) begin
					level_n = level_q + 32'sd1;
				end
			end
			KIND_DESTROY: begin
				if (!live_q && !drain_q) begin
					st_n = ST_NOT_INIT;
				end else begin
					live_n = 1'b0;
					if (count_q != '0) begin
						count_n = count_q - CNT_W'(1);
						wv_n    = 1'b1;
						wr_n    = 1'b1;
						last_n  = (count_q == CNT_W'(1));
						done    = last_n;
						drain_n = !last_n;
					end
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// held item register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (req.valid && req.ready) begin
			busy_q <= 1'b1;
		end else if (ex && done) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			kind_q <= kind_t'(req.kind);
			tid_q  <= req.thread_id;
			prio_q <= req.priority_req;
		end
	end

	// semaphore state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
			live_q  <= 1'b0;
			count_q <= '0;
			drain_q <= 1'b0;
		end else if (ex) begin
			level_q <= level_n;
			live_q  <= live_n;
			count_q <= count_n;
			drain_q <= drain_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (ex && emit) begin
			ov_q <= 1'b1;
		end else if (rsp.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ex && emit) begin
			status_q <= st_n;
			seen_q   <= seen_n;
			wv_q     <= wv_n;
			wt_q     <= wv_n ? cell_id[0] : 8'd0;
			wr_q     <= wr_n;
			last_q   <= last_n;
		end
	end

	assign rsp.valid        = ov_q;
	assign rsp.status       = status_q;
	assign rsp.level_seen   = seen_q;
	assign rsp.woken_valid  = wv_q;
	assign rsp.woken_thread = wt_q;
	assign rsp.woken_reason = wr_q;
	assign rsp.last         = last_q;

	// row of queue cells, head at index zero
	assign sel[0] = 1'b0;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic [7:0] p_id;
		logic [7:0] p_prio;
		logic [7:0] n_id;
		logic [7:0] n_prio;
		logic       occ;

		assign occ = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_head
			assign p_id   = tid_q;
			assign p_prio = prio_q;
		end else begin : g_mid
			assign p_id   = cell_id[i-1];
			assign p_prio = cell_prio[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign n_id   = cell_id[i];
			assign n_prio = cell_prio[i];
		end else begin : g_body
			assign n_id   = cell_id[i+1];
			assign n_prio = cell_prio[i+1];
		end

		csq_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.occ       (occ),
			.prev_id   (p_id),
			.prev_prio (p_prio),
			.next_id   (n_id),
			.next_prio (n_prio),
			.sel_in    (sel[i]),
			.sel_out   (sel[i+1]),
			.id        (cell_id[i]),
			.prio      (cell_prio[i])
		);
	end

	// waiter count never passes the queue depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("waiter count above queue depth");

	// a destroy drain only runs while an item is held
	a_drain_busy: assert property (@(posedge clk) disable iff (!arst_n)
		drain_q |-> busy_q)
		else $error("drain active without a held item");

	// released waiters always come with status ok
	a_woken_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.woken_valid) |-> (rsp.status == ST_OK))
		else $error("woken result with non-ok status");

	// a non-final destroy result keeps the item held for the next waiter
	a_drain_cont: assert property (@(posedge clk) disable iff (!arst_n)
		(ex && emit && !last_n) |=> (busy_q && drain_q))
		else $error("destroy drain stopped early");

endmodule

>>> test/testbench.sv
// self-checking bench for counting_semaphore_wait_queue: a directed table, then random phases
// an in-bench predictor of level, live flag and waiter queue checks every result transfer
// depends on csq_pkg, the csq_*_if interfaces and the block itself
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import csq_pkg::*;

	localparam int QDEPTH = 16;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES = 300;
	localparam int PRESSURE_AT = 120;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_REQS = 28;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam logic [2:0] KIND_SPARE_6 = 3'd6;
	localparam logic [2:0] KIND_SPARE_7 = 3'd7;

	typedef struct packed {
		status_t     status;
		logic [31:0] level_seen;
		logic        woken_valid;
		logic [7:0]  woken_thread;
		logic        woken_reason;
		logic        last;
	} sem_result_t;

	typedef struct packed {
		logic        is_cfg;
		reg_index_t  idx;
		logic [31:0] data;
		logic [2:0]  kind;
		logic [7:0]  tid;
		logic [7:0]  prio;
		logic        typed;
		status_t     st;
		logic [31:0] seen;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;

	csq_req_if req_ch();
	csq_rsp_if rsp_ch();
	csq_cfg_if cfg_ch();

	counting_semaphore_wait_queue #(.QUEUE_DEPTH(QDEPTH)) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_ch),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// predicted semaphore state and register copies
	logic signed [31:0] cfg_level = '0;
	logic               cfg_binary = 1'b0;
	logic               cfg_by_prio = 1'b0;
	logic signed [31:0] sem_level = '0;
	logic               sem_live = 1'b0;
	logic [7:0]         wq_id [QDEPTH];
	logic [7:0]         wq_prio [QDEPTH];
	int                 wq_count = 0;

	sem_result_t due_results[$];
	sem_result_t rsp_want;
	plan_row_t   plan[$];

	int  fail_count = 0;
	int  cycle_count = 0;
	int  n_items = 0;
	int  random_reqs = 0;
	int  n_reg_writes = 0;
	int  n_checked = 0;
	int  n_released = 0;
	int  n_full = 0;
	int  burst_left = 0;
	bit  steady_sender = 1'b0;
	bit  hold_request = 1'b0;
	bit  hold_done = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic sem_result_t mk_result(status_t st, logic [31:0] seen, logic wv,
			logic [7:0] wt, logic wr, logic lst);
		mk_result.status = st;
		mk_result.level_seen = seen;
		mk_result.woken_valid = wv;
		mk_result.woken_thread = wt;
		mk_result.woken_reason = wr;
		mk_result.last = lst;
	endfunction

	function automatic plan_row_t op(logic [2:0] k, logic [7:0] t, logic [7:0] p);
		op = '0;
		op.kind = k;
		op.tid = t;
		op.prio = p;
	endfunction

	function automatic plan_row_t op_exp(logic [2:0] k, logic [7:0] t, logic [7:0] p,
			status_t st, logic [31:0] seen);
		op_exp = op(k, t, p);
		op_exp.typed = 1'b1;
		op_exp.st = st;
		op_exp.seen = seen;
	endfunction

	function automatic plan_row_t reg_row(reg_index_t idx, logic [31:0] d);
		reg_row = '0;
		reg_row.is_cfg = 1'b1;
		reg_row.idx = idx;
		reg_row.data = d;
	endfunction

	// close the gap left by a waiter leaving the queue
	task automatic drop_waiter(int pos);
		for (int i = pos; i + 1 < wq_count; i++) begin
			wq_id[i] = wq_id[i + 1];
			wq_prio[i] = wq_prio[i + 1];
		end
		wq_count--;
	endtask

	// advance the predicted semaphore by one request and queue its results
	task automatic step_semaphore(logic [2:0] kind, logic [7:0] tid, logic [7:0] prio);
		int pos;
		logic [7:0] head;
		logic signed [31:0] seen;
		if (kind == KIND_SPARE_6 || kind == KIND_SPARE_7)
			return;
		if (kind == KIND_INIT) begin
			sem_level = cfg_binary ? ((cfg_level != 0) ? 32'sd1 : 32'sd0) : cfg_level;
			wq_count = 0;
			sem_live = 1'b1;
			due_results.push_back(mk_result(ST_OK, '0, 1'b0, '0, 1'b0, 1'b1));
			return;
		end
		// cancel works whether or not the semaphore is live
		if (kind == KIND_CANCEL) begin
			for (int i = 0; i < wq_count; i++) begin
				if (wq_id[i] == tid) begin
					drop_waiter(i);
					due_results.push_back(mk_result(ST_OK, '0, 1'b0, '0, 1'b0, 1'b1));
					return;
				end
			end
			due_results.push_back(mk_result(ST_NOT_FOUND, '0, 1'b0, '0, 1'b0, 1'b1));
			return;
		end
		if (!sem_live) begin
			due_results.push_back(mk_result(ST_NOT_INIT, '0, 1'b0, '0, 1'b0, 1'b1));
			return;
		end
		case (kind)
			KIND_WAIT: begin
				if (sem_level > 0) begin
					sem_level = sem_level - 1;
					due_results.push_back(mk_result(ST_OK, '0, 1'b0, '0, 1'b0, 1'b1));
				end else if (wq_count >= QDEPTH) begin
					due_results.push_back(mk_result(ST_QUEUE_FULL, '0, 1'b0, '0, 1'b0, 1'b1));
				end else begin
					// tail for fifo order, behind equal or higher priority otherwise
					pos = wq_count;
					if (cfg_by_prio) begin
						pos = 0;
						while (pos < wq_count && wq_prio[pos] >= prio)
							pos++;
					end
					for (int i = wq_count; i > pos; i--) begin
						wq_id[i] = wq_id[i - 1];
						wq_prio[i] = wq_prio[i - 1];
					end
					wq_id[pos] = tid;
					wq_prio[pos] = prio;
					wq_count++;
					due_results.push_back(mk_result(ST_QUEUED, '0, 1'b0, '0, 1'b0, 1'b1));
				end
			end
			KIND_TRY_WAIT: begin
				seen = sem_level;
				if (sem_level > 0) begin
					sem_level = sem_level - 1;
					due_results.push_back(mk_result(ST_OK, seen, 1'b0, '0, 1'b0, 1'b1));
				end else begin
					due_results.push_back(mk_result(ST_WOULD_BLOCK, seen, 1'b0, '0, 1'b0, 1'b1));
				end
			end
			KIND_POST: begin
				if (wq_count > 0) begin
					head = wq_id[0];
					drop_waiter(0);
					due_results.push_back(mk_result(ST_OK, '0, 1'b1, head, 1'b0, 1'b1));
				end else begin
					// saturate at the top, hold at one in binary mode
					if ((!cfg_binary || sem_level <= 0) && sem_level != LEVEL_MAX)
						sem_level = sem_level + 1;
					due_results.push_back(mk_result(ST_OK, '0, 1'b0, '0, 1'b0, 1'b1));
				end
			end
			default: begin
				// destroy releases every waiter in queue order
				sem_live = 1'b0;
				if (wq_count == 0)
					due_results.push_back(mk_result(ST_OK, '0, 1'b0, '0, 1'b0, 1'b1));
				for (int i = 0; i < wq_count; i++)
					due_results.push_back(mk_result(ST_OK, '0, 1'b1, wq_id[i], 1'b1,
						i + 1 == wq_count));
				wq_count = 0;
			end
		endcase
	endtask

	// offer one request and hold it until the transfer
	task automatic send_item(logic [2:0] kind, logic [7:0] tid, logic [7:0] prio, bit typed,
			sem_result_t typed_res);
		int n_before;
		req_ch.valid <= 1'b1;
		req_ch.kind <= kind;
		req_ch.thread_id <= tid;
		req_ch.priority_req <= prio;
		do @(negedge clk); while (!req_ch.ready);
		n_before = due_results.size();
		step_semaphore(kind, tid, prio);
		if (typed) begin
			while (due_results.size() > n_before)
				void'(due_results.pop_back());
			due_results.push_back(typed_res);
		end
		n_items++;
		@(posedge clk);
	endtask

	// bursts of requests with random gaps between them
	task automatic pace_sender();
		int gap;
		if (!steady_sender && burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			case ($urandom_range(0, 3))
				0: gap = 0;
				1, 2: gap = $urandom_range(1, 4);
				default: gap = $urandom_range(5, 20);
			endcase
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		if (burst_left > 0)
			burst_left--;
	endtask

	// register write once every expected result is back and the block has settled
	task automatic write_reg(reg_index_t idx, logic [31:0] data);
		req_ch.valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		do @(negedge clk); while (!cfg_ch.ready);
		case (idx)
			REG_INITIAL_LEVEL: cfg_level = data;
			REG_BINARY_MODE: cfg_binary = data[0];
			REG_QUEUE_BY_PRIO: cfg_by_prio = data[0];
			default: ;
		endcase
		n_reg_writes++;
		@(posedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// mostly well-formed traffic after an init, with some noise mixed in
	task automatic random_phase(int n_req, int wait_pct);
		int done;
		int r;
		bit first;
		logic [2:0] kind;
		logic [7:0] tid;
		logic [7:0] prio;
		done = 0;
		first = 1'b1;
		while (done < n_req) begin
			tid = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
			case ($urandom_range(0, 4))
				0: prio = 8'h00;
				1: prio = 8'hFF;
				2: prio = 8'($urandom_range(0, 3));
				default: prio = 8'($urandom_range(0, 255));
			endcase
			r = $urandom_range(0, 99);
			if (first && r < 90)
				kind = KIND_INIT;
			else if (!sem_live && r < 50)
				kind = KIND_INIT;
			else if (r < 3)
				kind = r[0] ? KIND_SPARE_7 : KIND_SPARE_6;
			else if (r < 6)
				kind = KIND_INIT;
			else if (r < 9)
				kind = KIND_DESTROY;
			else if ($urandom_range(0, 99) < wait_pct)
				kind = KIND_WAIT;
			else begin
				r = $urandom_range(0, 9);
				if (r < 4)
					kind = KIND_POST;
				else if (r < 7)
					kind = KIND_TRY_WAIT;
				else begin
					kind = KIND_CANCEL;
					if (wq_count > 0 && $urandom_range(0, 3) != 0)
						tid = wq_id[$urandom_range(0, wq_count - 1)];
				end
			end
			first = 1'b0;
			pace_sender();
			send_item(kind, tid, prio, 1'b0, '0);
			if (kind != KIND_SPARE_6 && kind != KIND_SPARE_7) begin
				done++;
				random_reqs++;
				if (random_reqs == PRESSURE_AT)
					hold_request = 1'b1;
			end
		end
	endtask

	// result receiver: stall patterns of its own, plus one long hold-off
	initial begin
		int len;
		int mode;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request && !hold_done) begin
				hold_done = 1'b1;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				mode = $urandom_range(0, 4);
				len = $urandom_range(5, 40);
				for (int k = 0; k < len; k++) begin
					case (mode)
						0, 1: rsp_ch.ready <= 1'b1;
						2: rsp_ch.ready <= 1'($urandom_range(0, 1));
						3: rsp_ch.ready <= (k % 4 != 3);
						default: rsp_ch.ready <= (k >= len - 3);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	// compare each result transfer against the oldest prediction
	always @(negedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (due_results.size() == 0) begin
				$error("result with nothing expected: status %0d woken %0d thread %0d",
					rsp_ch.status, rsp_ch.woken_valid, rsp_ch.woken_thread);
				fail_count++;
			end else begin
				rsp_want = due_results.pop_front();
				n_checked++;
				if (rsp_want.woken_valid)
					n_released++;
				if (rsp_want.status == ST_QUEUE_FULL)
					n_full++;
				if (rsp_ch.status !== rsp_want.status) begin
					$error("status: expected %0d, got %0d", rsp_want.status, rsp_ch.status);
					fail_count++;
				end
				if (rsp_ch.level_seen !== rsp_want.level_seen) begin
					$error("level_seen: expected %0d, got %0d", $signed(rsp_want.level_seen),
						$signed(rsp_ch.level_seen));
					fail_count++;
				end
				if (rsp_ch.woken_valid !== rsp_want.woken_valid) begin
					$error("woken_valid: expected %0d, got %0d", rsp_want.woken_valid,
						rsp_ch.woken_valid);
					fail_count++;
				end
				if (rsp_ch.woken_thread !== rsp_want.woken_thread) begin
					$error("woken_thread: expected %0d, got %0d", rsp_want.woken_thread,
						rsp_ch.woken_thread);
					fail_count++;
				end
				if (rsp_ch.woken_reason !== rsp_want.woken_reason) begin
					$error("woken_reason: expected %0d, got %0d", rsp_want.woken_reason,
						rsp_ch.woken_reason);
					fail_count++;
				end
				if (rsp_ch.last !== rsp_want.last) begin
					$error("last: expected %0d, got %0d", rsp_want.last, rsp_ch.last);
					fail_count++;
				end
			end
		end
	end

	// stimulus
	initial begin
		logic [31:0] lvl;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.kind <= KIND_INIT;
		req_ch.thread_id <= '0;
		req_ch.priority_req <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= REG_INITIAL_LEVEL;
		cfg_ch.data <= '0;

		// before init, spare codes, saturation at the top
		plan.push_back(op_exp(KIND_WAIT, 8'h01, 8'h01, ST_NOT_INIT, '0));
		plan.push_back(op_exp(KIND_TRY_WAIT, 8'h00, 8'h00, ST_NOT_INIT, '0));
		plan.push_back(op_exp(KIND_POST, 8'h00, 8'h00, ST_NOT_INIT, '0));
		plan.push_back(op_exp(KIND_DESTROY, 8'h00, 8'h00, ST_NOT_INIT, '0));
		plan.push_back(op_exp(KIND_CANCEL, 8'hFF, 8'h00, ST_NOT_FOUND, '0));
		plan.push_back(op(KIND_SPARE_6, 8'hAA, 8'h55));
		plan.push_back(op(KIND_SPARE_7, 8'h55, 8'hAA));
		plan.push_back(reg_row(REG_INITIAL_LEVEL, 32'h7FFF_FFFF));
		plan.push_back(op_exp(KIND_INIT, 8'h00, 8'h00, ST_OK, '0));
		plan.push_back(op_exp(KIND_TRY_WAIT, 8'h00, 8'h00, ST_OK, 32'h7FFF_FFFF));
		plan.push_back(op(KIND_POST, 8'h00, 8'h00));
		plan.push_back(op(KIND_POST, 8'h00, 8'h00));
		plan.push_back(op_exp(KIND_TRY_WAIT, 8'h00, 8'h00, ST_OK, 32'h7FFF_FFFF));
		// reinit while live at the bottom, priority queueing with a tie
		plan.push_back(reg_row(REG_INITIAL_LEVEL, 32'h8000_0000));
		plan.push_back(reg_row(REG_QUEUE_BY_PRIO, 32'd1));
		plan.push_back(op_exp(KIND_INIT, 8'h00, 8'h00, ST_OK, '0));
		plan.push_back(op_exp(KIND_TRY_WAIT, 8'h00, 8'h00, ST_WOULD_BLOCK, 32'h8000_0000));
		plan.push_back(op(KIND_WAIT, 8'h00, 8'h00));
		plan.push_back(op(KIND_WAIT, 8'hFF, 8'hFF));
		plan.push_back(op(KIND_WAIT, 8'h80, 8'hFF));
		plan.push_back(op(KIND_CANCEL, 8'h00, 8'h00));
		plan.push_back(op(KIND_POST, 8'h00, 8'h00));
		plan.push_back(op(KIND_WAIT, 8'h01, 8'h01));
		plan.push_back(op(KIND_DESTROY, 8'h00, 8'h00));
		plan.push_back(op_exp(KIND_POST, 8'h00, 8'h00, ST_NOT_INIT, '0));
		// binary mode clamps a negative level to one and holds it there
		plan.push_back(reg_row(REG_BINARY_MODE, 32'd1));
		plan.push_back(reg_row(REG_INITIAL_LEVEL, 32'hFFFF_FFFF));
		plan.push_back(op_exp(KIND_INIT, 8'h00, 8'h00, ST_OK, '0));
		plan.push_back(op(KIND_POST, 8'h00, 8'h00));
		plan.push_back(op_exp(KIND_TRY_WAIT, 8'h00, 8'h00, ST_OK, 32'd1));
		plan.push_back(op_exp(KIND_DESTROY, 8'h00, 8'h00, ST_OK, '0));
		plan.push_back(op_exp(KIND_CANCEL, 8'h05, 8'h00, ST_NOT_FOUND, '0));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg)
				write_reg(plan[i].idx, plan[i].data);
			else begin
				pace_sender();
				send_item(plan[i].kind, plan[i].tid, plan[i].prio, plan[i].typed,
					mk_result(plan[i].st, '0 | plan[i].seen, 1'b0, '0, 1'b0, 1'b1));
			end
		end

		// random phases, each under its own register setting
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: lvl = 32'h7FFF_FFFF;
				1: lvl = 32'h8000_0000;
				2: lvl = 32'd0;
				default:
					case ($urandom_range(0, 9))
						0: lvl = 32'h7FFF_FFFF;
						1: lvl = 32'h8000_0000;
						2: lvl = 32'hFFFF_FFFF;
						3: lvl = $urandom();
						default: lvl = $urandom_range(0, 4);
					endcase
			endcase
			write_reg(REG_INITIAL_LEVEL, lvl);
			write_reg(REG_BINARY_MODE, (p == 1) ? 32'd1 : (p < 3) ? 32'd0 :
				32'($urandom_range(0, 3) == 0));
			write_reg(REG_QUEUE_BY_PRIO, (p == 1) ? 32'd0 : (p < 3) ? 32'd1 :
				32'($urandom_range(0, 1)));
			steady_sender = (p == 5);
			random_phase(PHASE_REQS, (p == 2) ? 80 : $urandom_range(30, 75));
		end

		// drain and settle
		req_ch.valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES * 4) @(posedge clk);

		$display("Run covered %0d requests (%0d random) under %0d register writes, one long stall",
			n_items, random_reqs, n_reg_writes);
		$display("Checked %0d results: %0d thread releases, %0d full-queue refusals",
			n_checked, n_released, n_full);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
